// ===== sv/dhf_pkg.sv =====
`default_nettype none

package dhf_pkg;

  localparam int MAX_HITS_DEF = 64;

  localparam int CROSS_W = 16;
  localparam int ID_W    = 34;
  localparam int HIT_W   = ID_W + CROSS_W;
  localparam int WIN_W   = 17;
  localparam int POS_W   = 6;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Packed hit, identifiers above the crossing count.
  typedef struct packed {
    logic [2:0]         adc_code;
    logic [7:0]         amplitude;
    logic [4:0]         chip_number;
    logic [2:0]         fpga_number;
    logic [3:0]         module_number;
    logic [6:0]         channel_number;
    logic [3:0]         fem_number;
    logic [CROSS_W-1:0] crossing_full;
  } hit_t;

  // What travels down the cell chain with each hit.
  typedef struct packed {
    hit_t             hit;
    logic             clone;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             full;
  } tok_t;

  function automatic logic hit_match(hit_t earlier, hit_t cur, logic [WIN_W-1:0] win);
    logic [HIT_W-1:0]   e_w;
    logic [HIT_W-1:0]   c_w;
    logic [CROSS_W:0]   diff;
    logic [CROSS_W-1:0] abs_diff;
    e_w      = earlier;
    c_w      = cur;
    diff     = {1'b0, earlier.crossing_full} - {1'b0, cur.crossing_full};
    abs_diff = diff[CROSS_W] ? CROSS_W'(-diff) : diff[CROSS_W-1:0];
    return (e_w[HIT_W-1:CROSS_W] == c_w[HIT_W-1:CROSS_W]) && ({1'b0, abs_diff} < win);
  endfunction

endpackage

`default_nettype wire

// ===== sv/dhf_cell.sv =====
`default_nettype none

module dhf_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        adv,
  input  wire  [dhf_pkg::WIN_W-1:0]  win,
  input  wire                        in_vld,
  input  wire  dhf_pkg::tok_t        in_tok,
  input  wire  [CNT_W-1:0]           in_n,
  output logic                       out_vld,
  output dhf_pkg::tok_t              out_tok,
  output logic [CNT_W-1:0]           out_n
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  dhf_pkg::hit_t     ent_r;
  logic              vld_r;
  dhf_pkg::tok_t     tok_r;
  dhf_pkg::tok_t     tok_nxt;
  logic [CNT_W-1:0]  n_r;
  logic              hit_here;

  // entry counts only for hits that saw it filled on entry
  assign hit_here = (in_n > IDX_C) && dhf_pkg::hit_match(ent_r, in_tok.hit, win);

  always_comb begin
    tok_nxt       = in_tok;
    tok_nxt.clone = in_tok.clone | hit_here;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
      n_r   <= in_n;
      if (in_vld && (in_n == IDX_C)) begin
        ent_r <= in_tok.hit;
      end
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;
  assign out_n   = n_r;

endmodule

`default_nettype wire

// ===== sv/duplicate_hit_flagger.sv =====
// Throughput: one hit per cycle; each hit walks the chain of MAX_HITS cells,
// one cell per cycle, and a full output with tready low stalls the chain.
// Reset (rst_n low, synchronous): hit and position counts cleared, chain
// emptied, bco_window set to 1. Stored hit entries are not cleared.
`default_nettype none

module duplicate_hit_flagger #(
  parameter int MAX_HITS = dhf_pkg::MAX_HITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // input hits
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // [2:0] adc_code, [10:3] amplitude, [15:11] chip_number, [18:16] fpga_number,
  // [22:19] module_number, [29:23] channel_number, [33:30] fem_number,
  // [49:34] crossing_full, [55:50] zero
  input  wire  [55:0]               in_tdata,
  input  wire                       in_tlast,   // last_in_event
  // results
  output logic                      out_tvalid,
  input  wire                       out_tready,
  // [5:0] hit_position, [7:6] zero
  output logic [7:0]                out_tdata,
  // [0] is_clone, [1] store_full
  output logic [1:0]                out_tuser,
  output logic                      out_tlast,  // event_end
  // window register
  input  wire                       cfg_wr_en,
  input  wire  [dhf_pkg::WIN_W-1:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_HITS);

  logic [dhf_pkg::WIN_W-1:0] win_r;
  logic [CNT_W-1:0]          stored_count_r, stored_count_nxt;
  logic [dhf_pkg::POS_W-1:0] position_count_r, position_count_nxt;

  logic                      adv;
  logic                      acc;
  logic                      full;
  dhf_pkg::tok_t             in_tok;

  // chain wiring, index 0 is the chain head
  logic                      vld_w [MAX_HITS+1];
  dhf_pkg::tok_t             tok_w [MAX_HITS+1];
  logic [CNT_W-1:0]          n_w   [MAX_HITS+1];

  // whole chain moves together unless a result sits unclaimed
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && in_tready;

  // window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= dhf_pkg::WIN_W'(1);
    end else if (cfg_wr_en) begin
      win_r <= cfg_wr_data;
    end
  end

  // fill and position counts, tracked at entry
  assign full = (stored_count_r >= MAX_C);

  always_comb begin
    stored_count_nxt   = stored_count_r;
    position_count_nxt = position_count_r;
    if (acc) begin
      if (in_tlast) begin
        stored_count_nxt   = '0;
        position_count_nxt = '0;
      end else begin
        if (!full) begin
          stored_count_nxt = stored_count_r + CNT_W'(1);
        end
        if (position_count_r != dhf_pkg::POS_MAX) begin
          position_count_nxt = position_count_r + dhf_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_count_r   <= '0;
      position_count_r <= '0;
    end else begin
      stored_count_r   <= stored_count_nxt;
      position_count_r <= position_count_nxt;
    end
  end

  // unpack the incoming transaction into a chain token
  always_comb begin
    in_tok                    = '0;
    in_tok.hit.adc_code       = in_tdata[2:0];
    in_tok.hit.amplitude      = in_tdata[10:3];
    in_tok.hit.chip_number    = in_tdata[15:11];
    in_tok.hit.fpga_number    = in_tdata[18:16];
    in_tok.hit.module_number  = in_tdata[22:19];
    in_tok.hit.channel_number = in_tdata[29:23];
    in_tok.hit.fem_number     = in_tdata[33:30];
    in_tok.hit.crossing_full  = in_tdata[49:34];
    in_tok.clone              = 1'b0;
    in_tok.pos                = position_count_r;
    in_tok.last               = in_tlast;
    in_tok.full               = full;
  end

  // the token carries the fill count seen on entry: cell j compares only
  // when j is below it and stores the hit when j equals it
  assign vld_w[0] = acc;
  assign tok_w[0] = in_tok;
  assign n_w[0]   = stored_count_r;

  for (genvar j = 0; j < MAX_HITS; j++) begin : g_cell
    dhf_cell #(
      .CNT_W (CNT_W),
      .IDX   (j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .win     (win_r),
      .in_vld  (vld_w[j]),
      .in_tok  (tok_w[j]),
      .in_n    (n_w[j]),
      .out_vld (vld_w[j+1]),
      .out_tok (tok_w[j+1]),
      .out_n   (n_w[j+1])
    );
  end

  // last cell's token register is the output register
  assign out_tvalid = vld_w[MAX_HITS];
  assign out_tdata  = {2'b00, tok_w[MAX_HITS].pos};
  assign out_tuser  = {tok_w[MAX_HITS].full, tok_w[MAX_HITS].clone};
  assign out_tlast  = tok_w[MAX_HITS].last;

  // fill count never runs past the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_count_r <= MAX_C)
    else $error("stored count above store depth");

  // end of event empties the store and restarts positions
  a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> (stored_count_r == '0) && (position_count_r == '0))
    else $error("event end did not clear counts");

  // a hit stored at entry grows the count by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_tlast && !full |=> stored_count_r == $past(stored_count_r) + CNT_W'(1))
    else $error("fill count did not advance");

  // a delivered full flag must match the count the hit saw on entry
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1] == (n_w[MAX_HITS] >= MAX_C)))
    else $error("store_full disagrees with entry count");

endmodule

`default_nettype wire

// ===== tb/sv/dhf_checker.sv =====
module dhf_checker
  import dhf_pkg::*;
#(
  parameter int MAX_HITS = MAX_HITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  input  wire              in_tready,
  input  wire [55:0]       in_tdata,
  input  wire              in_tlast,
  input  wire              out_tvalid,
  input  wire              out_tready,
  input  wire [7:0]        out_tdata,
  input  wire [1:0]        out_tuser,
  input  wire              out_tlast,
  input  wire              cfg_wr_en,
  input  wire [WIN_W-1:0]  cfg_wr_data,
  output int               pending,
  output int               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             clone;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             full;
  } hit_flags_t;

  hit_t             event_hits [MAX_HITS];
  int               held_hits;
  int               next_pos;
  logic [WIN_W-1:0] window;
  hit_flags_t       flags_due [$];

  function automatic hit_t unpack_hit(logic [55:0] d);
    hit_t h;
    h.adc_code       = d[2:0];
    h.amplitude      = d[10:3];
    h.chip_number    = d[15:11];
    h.fpga_number    = d[18:16];
    h.module_number  = d[22:19];
    h.channel_number = d[29:23];
    h.fem_number     = d[33:30];
    h.crossing_full  = d[49:34];
    return h;
  endfunction

  // All identifiers equal, crossing count ignored.
  function automatic logic same_source(hit_t a, hit_t b);
    hit_t t;
    t = a;
    t.crossing_full = b.crossing_full;
    return t == b;
  endfunction

  // Flags for one hit; updates the event store and position.
  function automatic hit_flags_t predict_flags(hit_t h, logic last);
    hit_flags_t f;
    int         gap;
    f.clone = 1'b0;
    for (int i = 0; i < held_hits; i++) begin
      gap = int'(event_hits[i].crossing_full) - int'(h.crossing_full);
      if (gap < 0) begin
        gap = -gap;
      end
      if (same_source(event_hits[i], h) && gap < int'(window)) begin
        f.clone = 1'b1;
      end
    end
    f.full = (held_hits >= MAX_HITS);
    if (!f.full) begin
      event_hits[held_hits] = h;
      held_hits++;
    end
    f.pos  = POS_W'(next_pos);
    f.last = last;
    if (next_pos < int'(POS_MAX)) begin
      next_pos++;
    end
    if (last) begin
      held_hits = 0;
      next_pos  = 0;
    end
    return f;
  endfunction

  task automatic flag_error(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("dhf_checker: %s at %0t: expected %0d, got %0d", what, $time, want, got);
    end
  endtask

  task automatic check_result();
    hit_flags_t want;
    if (flags_due.size() == 0) begin
      flag_error("result with nothing outstanding, hit_position", 0, out_tdata[5:0]);
    end else begin
      want = flags_due.pop_front();
      if (out_tuser[0] !== want.clone) flag_error("is_clone", want.clone, out_tuser[0]);
      if (out_tuser[1] !== want.full) flag_error("store_full", want.full, out_tuser[1]);
      if (out_tdata[5:0] !== want.pos) flag_error("hit_position", want.pos, out_tdata[5:0]);
      if (out_tdata[7:6] !== 2'b00) flag_error("tdata padding", 0, out_tdata[7:6]);
      if (out_tlast !== want.last) flag_error("event_end", want.last, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_hits = 0;
      next_pos  = 0;
      window    = WIN_W'(1);
      flags_due.delete();
    end else begin
      if (cfg_wr_en) begin
        window = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        flags_due = {flags_due, predict_flags(unpack_hit(in_tdata), in_tlast)};
      end
      if (out_tvalid && out_tready) begin
        check_result();
      end
    end
    pending = flags_due.size();
  end

endmodule

// ===== tb/sv/tb_duplicate_hit_flagger.sv =====
module tb_duplicate_hit_flagger;
  timeunit 1ns;
  timeprecision 1ps;
  import dhf_pkg::*;

  localparam int MAX_HITS  = MAX_HITS_DEF;
  localparam int RUN_LIMIT = 200000;   // cycles
  localparam int LONG_HOLD = 400;      // receiver hold-off, well past the chain depth

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [55:0]      in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;
  logic             cfg_wr_en;
  logic [WIN_W-1:0] cfg_wr_data;

  int pending;
  int fail_count;
  int cycle_count = 0;

  // Idle rates in percent, changed per phase by the stimulus process.
  int send_idle_pct = 35;
  int recv_idle_pct = 61;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int hold_reqs = 0;

  duplicate_hit_flagger #(
    .MAX_HITS(MAX_HITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Watches both channels and the window port, predicts and compares.
  dhf_checker #(
    .MAX_HITS(MAX_HITS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_duplicate_hit_flagger: FAIL");
      $finish;
    end
  end

  // Result side: random backpressure, plus one long hold-off on request so
  // the cell chain stalls and in_tready drops while hits keep coming.
  initial begin
    int hold_taken;
    int stall_left;
    hold_taken = 0;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_taken) begin
        hold_taken = hold_reqs;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // tdata layout, lowest bits first: adc, amplitude, chip, fpga, module,
  // channel, fem, crossing, then zero padding.
  function automatic logic [55:0] pack_hit(hit_t h);
    return {6'b0, h.crossing_full, h.fem_number, h.channel_number, h.module_number,
            h.fpga_number, h.chip_number, h.amplitude, h.adc_code};
  endfunction

  function automatic hit_t random_hit();
    logic [63:0] r;
    hit_t        h;
    r = {$urandom, $urandom};
    h = r[HIT_W-1:0];
    // Pull the crossing count onto its ends now and then.
    case ($urandom_range(7))
      0: h.crossing_full = '0;
      1: h.crossing_full = '1;
      default: ;
    endcase
    return h;
  endfunction

  // Crossing count around base, aimed half the time at the window boundary.
  function automatic logic [CROSS_W-1:0] near_crossing(logic [CROSS_W-1:0] base,
                                                       int unsigned win);
    int off;
    int c;
    case ($urandom_range(5))
      0: off = 0;
      1: off = int'(win) - 1;
      2: off = int'(win);
      3: off = int'(win) + 1;
      4: off = $urandom_range(255);
      default: off = $urandom_range(65535);
    endcase
    if ($urandom_range(1) == 1) begin
      off = -off;
    end
    c = int'(base) + off;
    if (c < 0 || c > 65535) begin
      c = int'(base) - off;
    end
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    return CROSS_W'(c);
  endfunction

  // One input transaction. Called and returns right after a rising edge.
  // Ready is looked at on the falling edge, where everything has settled.
  task automatic send_hit(input hit_t h, input logic last);
    logic ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_hit(h);
    in_tlast  <= last;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  task automatic send_copy(input hit_t h, input int unsigned crossing, input logic last);
    h.crossing_full = CROSS_W'(crossing);
    send_hit(h, last);
  endtask

  // Stop offering and wait until every outstanding result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    @(posedge clk);
  endtask

  // Window writes only happen with the block drained.
  task automatic write_window(input int unsigned value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= WIN_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One event: a few source hits repeated at crossings around the window,
  // mixed with unrelated hits and near misses differing in one id bit.
  task automatic run_event(input int len, input int unsigned win);
    hit_t             pool [4];
    hit_t             h;
    logic [HIT_W-1:0] bits;
    int               npool;
    int               k;
    int               flip;
    npool = $urandom_range(1, 4);
    for (int j = 0; j < 4; j++) begin
      pool[j] = random_hit();
    end
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(npool - 1);
      case ($urandom_range(7))
        0, 1: h = random_hit();
        2: begin
          bits = pool[k];
          flip = $urandom_range(HIT_W - 1, CROSS_W);
          bits[flip] = ~bits[flip];
          h = bits;
        end
        default: begin
          h = pool[k];
          h.crossing_full = near_crossing(pool[k].crossing_full, win);
        end
      endcase
      send_hit(h, i == len - 1);
    end
  endtask

  initial begin
    hit_t        zero_hit;
    hit_t        max_hit;
    hit_t        max_miss;
    int unsigned win_plan [8];
    int          sent;
    int          len;
    logic        first_event;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    zero_hit    = '0;
    max_hit     = '1;
    max_miss    = '1;
    max_miss.chip_number = 5'h1e;
    // Zero window, boundary windows, past the crossing range, full register.
    win_plan = '{16, 0, 65535, 3, 65536, 131071, 300, 1};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: window from reset (1), only equal crossings are clones.
    send_copy(zero_hit, 0, 1'b0);
    send_copy(zero_hit, 0, 1'b0);       // exact repeat -> clone
    send_copy(zero_hit, 1, 1'b0);       // one crossing apart -> outside window
    send_copy(max_hit, 65535, 1'b0);
    send_copy(max_hit, 0, 1'b0);        // full span, no wrap -> original
    send_copy(max_hit, 65535, 1'b0);    // clone
    send_copy(max_miss, 65535, 1'b0);   // one id differs -> original
    send_copy(zero_hit, 0, 1'b1);       // clone, closes the event

    // Zero window: nothing is ever a clone.
    write_window(0);
    send_copy(zero_hit, 0, 1'b0);
    send_copy(zero_hit, 0, 1'b1);

    // Window above the crossing range: any matching earlier hit counts.
    write_window(65536);
    send_copy(max_hit, 0, 1'b0);
    send_copy(max_hit, 65535, 1'b0);
    send_copy(zero_hit, 65535, 1'b0);
    send_copy(zero_hit, 0, 1'b1);

    // Window 65535: a full-span difference just misses.
    write_window(65535);
    send_copy(max_hit, 0, 1'b0);
    send_copy(max_hit, 65535, 1'b0);
    send_copy(max_hit, 65534, 1'b1);

    // Random phases. Idle mix: sender 35/receiver 61, then swapped, then none.
    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 61;
      end else if (p < 6) begin
        send_idle_pct = 61;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_window(win_plan[p]);
      if (p == 1) begin
        hold_reqs++;
      end
      sent        = 0;
      first_event = 1'b1;
      while (sent < 113) begin
        // First event of each phase overflows the store and saturates the
        // position; the rest are short, some a single hit.
        if (first_event) begin
          len = $urandom_range(80, 66);
        end else if ($urandom_range(9) == 0) begin
          len = 1;
        end else begin
          len = $urandom_range(20, 2);
        end
        run_event(len, win_plan[p]);
        sent += len;
        first_event = 1'b0;
      end
    end

    drain();
    repeat (MAX_HITS + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_duplicate_hit_flagger: PASS");
    end else begin
      $display("tb_duplicate_hit_flagger: FAIL");
    end
    $finish;
  end

endmodule
